// ===== sv/rtmcl_pkg.sv =====
// Shared constants for the record-then-match code lock.
`timescale 1ns / 1ps

package rtmcl_pkg;

    localparam int CODE_DEPTH     = 128;
    localparam int CODEPOINT_BITS = 21;

    // Port field widths
    localparam int MODE_W     = 2;
    localparam int CP_W       = 21;
    localparam int PHASE_W    = 2;
    localparam int COUNT_W    = 7;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;

endpackage

// ===== sv/record_then_match_code_lock.sv =====
// Top level of the record-then-match code lock.
//
//  channel | dir | tdata (low bit up)                              | tuser
//  s_      | in  | codepoint[20:0], zero pad to 24                 | mode[1:0]
//  m_      | out | phase[1:0] entered_count[8:2] unlock[9]         | -
//          |     | view_restart[10], zero pad to 16                |
//
// One item per cycle while the output buffer has room. Control state updates in the
// accept cycle and the result is registered right away; a character compare reads the code
// RAM and settles the match flag in the cycle after, forwarded to the next item.
// A two-entry output buffer keeps s_tready high while one result waits.
// Reset is synchronous (aresetn low); unwritten code entries read as zero by
// way of a fill count, so there is no clearing pass.
`timescale 1ns / 1ps

module record_then_match_code_lock #(
    parameter int CODE_DEPTH     = rtmcl_pkg::CODE_DEPTH,
    parameter int CODEPOINT_BITS = rtmcl_pkg::CODEPOINT_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rtmcl_pkg::S_TDATA_W-1:0]  s_tdata,  // codepoint[20:0], pad
    input  logic [rtmcl_pkg::MODE_W-1:0]     s_tuser,  // mode[1:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rtmcl_pkg::M_TDATA_W-1:0]  m_tdata   // phase, count, unlock, restart
);

    localparam int IW = (CODE_DEPTH > 1) ? $clog2(CODE_DEPTH) : 1;
    localparam int FW = $clog2(CODE_DEPTH + 1);
    localparam int CW = CODEPOINT_BITS;

    typedef enum logic [1:0] {
        PH_WAIT     = 2'd0,
        PH_RECORD   = 2'd1,
        PH_COMPARE  = 2'd2,
        PH_UNLOCKED = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KEY_POINTER = 2'd0,
        KEY_ESCAPE  = 2'd1,
        KEY_SUBMIT  = 2'd2,
        KEY_CHAR    = 2'd3
    } key_t;

    phase_t phase_reg, phase_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] len_reg, len_next;
    logic          match_reg, match_next;
    logic [FW-1:0] fill_reg, fill_next;

    // compare stage
    logic          cmp_v_reg;
    logic [CW-1:0] cmp_cp_reg;
    logic          cmp_hit_reg;

    // output buffer
    logic                             out_v_reg, skid_v_reg;
    logic [rtmcl_pkg::M_TDATA_W-1:0]  out_reg, skid_reg;

    logic          accept, pop;
    key_t          key;
    phase_t        ph;
    logic [63:0]   cp_ext;
    logic [CW-1:0] cp;
    logic [CW-1:0] ram_rdata;
    logic          ram_we;
    logic          rd_cmp;
    logic          cmp_eq;
    logic          match_eff;
    logic          ovr, ovr_val;
    logic          unlock, restart;
    logic [31:0]   idx_ext;
    logic [rtmcl_pkg::M_TDATA_W-1:0] result;

    assign accept   = s_tvalid && s_tready;
    assign pop      = out_v_reg && m_tready;
    assign s_tready = !skid_v_reg;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

    assign key    = key_t'(s_tuser);
    assign cp_ext = 64'(s_tdata[rtmcl_pkg::CP_W-1:0]);
    assign cp     = cp_ext[CW-1:0];

    rtmcl_ram #(
        .WIDTH (CW),
        .DEPTH (CODE_DEPTH),
        .AW    (IW)
    ) u_code_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (cp),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // entries past the fill count were never written and read as zero
    assign cmp_eq    = cmp_hit_reg ? (ram_rdata == cmp_cp_reg) : (cmp_cp_reg == '0);
    assign match_eff = cmp_v_reg ? (match_reg && cmp_eq) : match_reg;

    always_comb begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        fill_next  = fill_reg;
        ovr        = 1'b0;
        ovr_val    = 1'b0;
        unlock     = 1'b0;
        restart    = 1'b0;
        ram_we     = 1'b0;
        rd_cmp     = 1'b0;
        ph         = (phase_reg == PH_WAIT) ? PH_RECORD : phase_reg;

        if (accept && phase_reg != PH_UNLOCKED) begin
            if (phase_reg == PH_WAIT) begin
                phase_next = PH_RECORD;
                ovr        = 1'b1;
                ovr_val    = 1'b0;
                restart    = 1'b1;
            end
            case (key)
                KEY_POINTER: begin
                end
                KEY_ESCAPE: begin
                    if (idx_reg != '0) begin
                        restart = 1'b1;
                        ovr     = 1'b1;
                        ovr_val = (ph == PH_COMPARE);
                    end
                    idx_next = '0;
                end
                KEY_SUBMIT: begin
                    if (ph == PH_COMPARE) begin
                        unlock  = match_eff && (idx_reg == len_reg);
                        restart = 1'b1;
                        ovr     = 1'b1;
                        ovr_val = 1'b1;
                        if (unlock) begin
                            phase_next = PH_UNLOCKED;
                        end
                    end else if (idx_reg != '0) begin
                        len_next   = idx_reg;
                        phase_next = PH_COMPARE;
                        ovr        = 1'b1;
                        ovr_val    = 1'b1;
                        restart    = 1'b1;
                    end
                    idx_next = '0;
                end
                KEY_CHAR: begin
                    if (ph == PH_RECORD) begin
                        ram_we = 1'b1;
                        if (FW'(idx_reg) >= fill_reg) begin
                            fill_next = FW'(idx_reg) + FW'(1);
                        end
                    end else begin
                        rd_cmp = 1'b1;
                    end
                    idx_next = (idx_reg == IW'(CODE_DEPTH - 1)) ? '0 : idx_reg + IW'(1);
                end
                default: begin
                end
            endcase
        end

        match_next = ovr ? ovr_val : match_eff;

        idx_ext = 32'(idx_next);
        result  = '0;
        result[1:0]  = phase_next;
        result[8:2]  = idx_ext[rtmcl_pkg::COUNT_W-1:0];
        result[9]    = unlock;
        result[10]   = restart;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_WAIT;
            idx_reg     <= '0;
            len_reg     <= '0;
            match_reg   <= 1'b0;
            fill_reg    <= '0;
            cmp_v_reg   <= 1'b0;
            out_v_reg   <= 1'b0;
            skid_v_reg  <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            len_reg     <= len_next;
            match_reg   <= match_next;
            fill_reg    <= fill_next;
            cmp_v_reg   <= rd_cmp;
            cmp_cp_reg  <= cp;
            cmp_hit_reg <= (FW'(idx_reg) < fill_reg);

            if (skid_v_reg) begin
                if (pop) begin
                    out_reg    <= skid_reg;
                    skid_v_reg <= 1'b0;
                end
            end else if (accept) begin
                if (!out_v_reg || pop) begin
                    out_reg   <= result;
                    out_v_reg <= 1'b1;
                end else begin
                    skid_reg   <= result;
                    skid_v_reg <= 1'b1;
                end
            end else if (pop) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    a_unlock_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9] |-> m_tdata[1:0] == PH_UNLOCKED)
        else $error("unlock shown outside unlocked phase");

    a_unlock_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_UNLOCKED |=> phase_reg == PH_UNLOCKED)
        else $error("left unlocked phase");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(CODE_DEPTH))
        else $error("fill count past depth");

    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry without head entry");

endmodule

// ===== sv/rtmcl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rtmcl_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
